>>> rtl/pwdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwdc_pkg
// Shared types, codes and rounding helper for the pedal and wheel drive
// command unit.
// ----------------------------------------------------------------------------
package pwdc_pkg;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned OPA_W  = 32;
    localparam int unsigned OPB_W  = 16;
    localparam int unsigned PROD_W = OPA_W + OPB_W;

    localparam logic [2:0] REG_LIN_GAIN           = 3'd0;
    localparam logic [2:0] REG_ANG_GAIN           = 3'd1;
    localparam logic [2:0] REG_BOOST_GAIN         = 3'd2;
    localparam logic [2:0] REG_BOOST_EN           = 3'd3;
    localparam logic [2:0] REG_DM_NEEDED          = 3'd4;
    localparam logic [2:0] REG_THROTTLE_THRESHOLD = 3'd5;
    localparam logic [2:0] REG_BRAKE_THRESHOLD    = 3'd6;

    localparam logic [1:0] GEAR_UNKNOWN = 2'd0;
    localparam logic [1:0] GEAR_FORWARD = 2'd1;
    localparam logic [1:0] GEAR_REVERSE = 2'd2;

    localparam logic [1:0] FACTOR_ZERO = 2'b00;
    localparam logic [1:0] FACTOR_POS  = 2'b01;
    localparam logic [1:0] FACTOR_NEG  = 2'b11;

    localparam logic [1:0] SH_14 = 2'd0;
    localparam logic [1:0] SH_15 = 2'd1;
    localparam logic [1:0] SH_27 = 2'd2;

    localparam logic [PROD_W:0] OUT_LIMIT = (PROD_W + 1)'(262144);

    typedef struct packed {
        logic signed [15:0] steering_axis;
        logic signed [15:0] deadman_axis;
        logic signed [15:0] throttle_axis;
        logic signed [15:0] brake_axis;
        logic        [3:0]  axis_present;
        logic               forward_button;
        logic               reverse_button;
        logic               turbo_button;
        logic        [2:0]  button_present;
    } t_in;

    typedef struct packed {
        logic signed [19:0] linear_velocity;
        logic signed [19:0] angular_velocity;
        logic        [1:0]  gear;
    } t_out;

    typedef struct packed {
        logic [15:0] lin_gain;
        logic [15:0] ang_gain;
        logic [15:0] boost_gain;
        logic        boost_en;
        logic        dm_needed;
        logic [14:0] throttle_threshold;
        logic [14:0] brake_threshold;
    } t_cfg;

    // round to nearest with ties up on the magnitude, saturate, apply sign
    function automatic logic [19:0] finish(input logic [PROD_W-1:0] mag,
                                           input logic [1:0] sh_sel,
                                           input logic neg);
        logic [PROD_W:0] ext;
        logic [PROD_W:0] r;
        logic [19:0]     m;
        ext = {1'b0, mag};
        case (sh_sel)
            SH_14:   r = (ext + (PROD_W + 1)'(1 << 13)) >> 14;
            SH_15:   r = (ext + (PROD_W + 1)'(1 << 14)) >> 15;
            SH_27:   r = (ext + (PROD_W + 1)'(1 << 26)) >> 27;
            default: r = '0;
        endcase
        if (r > OUT_LIMIT) begin
            r = OUT_LIMIT;
        end
        m = r[19:0];
        return neg ? (20'd0 - m) : m;
    endfunction

endpackage

>>> rtl/pedal_wheel_drive_command_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedal_wheel_drive_command_unit
// Turns one wheel and pedal sample into a speed, a turn rate and a gear.
// A stop (deadman or low throttle) goes from evaluation back to idle; braking
// adds a multiply and a finish state; driving adds the linear multiply, a
// turbo multiply if turbo, and the linear and angular finish states. The one
// shared 32x16 multiplier serves all products; input ready is high only while
// idle with no result pending. Synchronous active-low reset restores register
// defaults, forward gear, factor +1 and zero held commands; no clearing pass.
// ----------------------------------------------------------------------------
module pedal_wheel_drive_command_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  pwdc_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output pwdc_pkg::t_out                o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pwdc_pkg::ADDR_W-1:0]   paddr,
    input  logic [pwdc_pkg::DATA_W-1:0]   pwdata,
    output logic [pwdc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_EVAL    = 8'b0000_0010,
        S_MUL_BRK = 8'b0000_0100,
        S_FIN_BRK = 8'b0000_1000,
        S_MUL_LIN = 8'b0001_0000,
        S_MUL_TRB = 8'b0010_0000,
        S_FIN_LIN = 8'b0100_0000,
        S_FIN_ANG = 8'b1000_0000
    } t_state;

    pwdc_pkg::t_cfg w_cfg;
    pwdc_pkg::t_in  r_in;
    pwdc_pkg::t_out r_out;
    pwdc_pkg::t_out n_out;
    t_state         r_state, n_state;
    logic           r_out_vld, n_out_vld;
    logic           r_pend, n_pend;
    logic [1:0]     r_gear, n_gear;
    logic [1:0]     r_factor, n_factor;
    logic           r_prev_fwd, n_prev_fwd;
    logic           r_prev_rev, n_prev_rev;
    logic signed [19:0] r_last_lin, n_last_lin;
    logic signed [19:0] r_last_ang, n_last_ang;

    logic [pwdc_pkg::OPA_W-1:0]  w_op_a;
    logic [pwdc_pkg::OPB_W-1:0]  w_op_b;
    logic [pwdc_pkg::PROD_W-1:0] w_prod;

    logic signed [17:0] w_deadman, w_throttle, w_brake, w_rest;
    logic signed [17:0] w_brake_lim, w_thr_lim;
    logic signed [16:0] w_steer;
    logic [17:0]        w_rest_abs;
    logic [16:0]        w_steer_abs;
    logic [19:0]        w_lin_abs;
    logic               w_turbo, w_accept, w_slot, w_frel, w_rrel;

    pwdc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pwdc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_op_a),
        .i_b    (w_op_b),
        .o_prod (w_prod)
    );

    // normalized pedals, absent axes read as zero
    assign w_deadman  = r_in.axis_present[1] ?
                        (18'(r_in.deadman_axis) + 18'sd16384) : 18'sd0;
    assign w_throttle = r_in.axis_present[2] ?
                        (18'(r_in.throttle_axis) + 18'sd16384) : 18'sd0;
    assign w_brake    = r_in.axis_present[3] ?
                        (18'(r_in.brake_axis) + 18'sd16384) : 18'sd0;
    assign w_steer    = r_in.axis_present[0] ? 17'(r_in.steering_axis) : 17'sd0;
    assign w_rest     = 18'sd32768 - w_brake;
    assign w_brake_lim = $signed({2'b00, w_cfg.brake_threshold, 1'b0});
    assign w_thr_lim   = $signed({2'b00, w_cfg.throttle_threshold, 1'b0});
    assign w_rest_abs  = w_rest[17] ? 18'(-w_rest) : 18'(w_rest);
    assign w_steer_abs = w_steer[16] ? 17'(-w_steer) : 17'(w_steer);
    assign w_lin_abs   = r_last_lin[19] ? 20'(-r_last_lin) : 20'(r_last_lin);
    assign w_turbo     = w_cfg.boost_en && r_in.button_present[2] && r_in.turbo_button;
    assign w_frel      = !r_in.forward_button && r_prev_fwd;
    assign w_rrel      = !r_in.reverse_button && r_prev_rev;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_slot     = !r_out_vld || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && !r_pend;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_comb begin
        case (r_state)
            S_MUL_BRK: begin
                w_op_a = {13'd0, w_lin_abs[18:0]};
                w_op_b = w_rest_abs[15:0];
            end
            S_MUL_LIN: begin
                w_op_a = {16'd0, w_cfg.lin_gain};
                w_op_b = w_throttle[15:0];
            end
            S_MUL_TRB: begin
                w_op_a = w_prod[31:0];
                w_op_b = w_cfg.boost_gain;
            end
            S_FIN_LIN: begin
                w_op_a = {16'd0, w_cfg.ang_gain};
                w_op_b = w_steer_abs[15:0];
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_pend     = r_pend;
        n_gear     = r_gear;
        n_factor   = r_factor;
        n_prev_fwd = r_prev_fwd;
        n_prev_rev = r_prev_rev;
        n_last_lin = r_last_lin;
        n_last_ang = r_last_ang;
        n_out_vld  = r_out_vld && !i_out_ready;
        n_out      = r_out;
        case (r_state)
            S_IDLE: begin
                if (r_pend && w_slot) begin
                    n_out_vld = 1'b1;
                    n_out     = '{linear_velocity:  r_last_lin,
                                  angular_velocity: r_last_ang,
                                  gear:             r_gear};
                    n_pend    = 1'b0;
                end else if (w_accept) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (w_cfg.dm_needed && (w_deadman <= 18'sd0)) begin
                    n_last_lin = '0;
                    n_last_ang = '0;
                    n_pend     = 1'b1;
                    n_state    = S_IDLE;
                end else if (w_brake > w_brake_lim) begin
                    // gear selection on button release
                    if (r_in.button_present[1:0] != 2'b11) begin
                        n_gear = pwdc_pkg::GEAR_UNKNOWN;
                    end else begin
                        if (r_gear == pwdc_pkg::GEAR_FORWARD) begin
                            if (w_rrel) n_gear = pwdc_pkg::GEAR_REVERSE;
                        end else if (r_gear == pwdc_pkg::GEAR_REVERSE) begin
                            if (w_frel) n_gear = pwdc_pkg::GEAR_FORWARD;
                        end else begin
                            if (w_frel)      n_gear = pwdc_pkg::GEAR_FORWARD;
                            else if (w_rrel) n_gear = pwdc_pkg::GEAR_REVERSE;
                        end
                        n_prev_fwd = r_in.forward_button;
                        n_prev_rev = r_in.reverse_button;
                        n_factor   = (n_gear == pwdc_pkg::GEAR_FORWARD) ? pwdc_pkg::FACTOR_POS :
                                     (n_gear == pwdc_pkg::GEAR_REVERSE) ? pwdc_pkg::FACTOR_NEG :
                                                                          pwdc_pkg::FACTOR_ZERO;
                    end
                    n_state = S_MUL_BRK;
                end else if (w_throttle <= w_thr_lim) begin
                    n_last_lin = '0;
                    n_last_ang = '0;
                    n_pend     = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_MUL_LIN;
                end
            end
            S_MUL_BRK: begin
                n_state = S_FIN_BRK;
            end
            S_FIN_BRK: begin
                if ((r_factor == pwdc_pkg::FACTOR_ZERO) || (w_rest == 18'sd0)) begin
                    n_last_lin = '0;
                end else begin
                    n_last_lin = $signed(pwdc_pkg::finish(w_prod, pwdc_pkg::SH_15,
                                     w_rest[17] != (r_factor == pwdc_pkg::FACTOR_NEG)));
                end
                n_pend  = 1'b1;
                n_state = S_IDLE;
            end
            S_MUL_LIN: begin
                n_state = w_turbo ? S_MUL_TRB : S_FIN_LIN;
            end
            S_MUL_TRB: begin
                n_state = S_FIN_LIN;
            end
            S_FIN_LIN: begin
                if (r_factor == pwdc_pkg::FACTOR_ZERO) begin
                    n_last_lin = '0;
                end else begin
                    n_last_lin = $signed(pwdc_pkg::finish(w_prod,
                                     w_turbo ? pwdc_pkg::SH_27 : pwdc_pkg::SH_15,
                                     r_factor == pwdc_pkg::FACTOR_NEG));
                end
                n_state = S_FIN_ANG;
            end
            S_FIN_ANG: begin
                n_last_ang = $signed(pwdc_pkg::finish(w_prod, pwdc_pkg::SH_14, w_steer[16]));
                n_pend     = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pend     <= 1'b0;
            r_out_vld  <= 1'b0;
            r_gear     <= pwdc_pkg::GEAR_FORWARD;
            r_factor   <= pwdc_pkg::FACTOR_POS;
            r_prev_fwd <= 1'b0;
            r_prev_rev <= 1'b0;
            r_last_lin <= '0;
            r_last_ang <= '0;
        end else begin
            r_state    <= n_state;
            r_pend     <= n_pend;
            r_out_vld  <= n_out_vld;
            r_gear     <= n_gear;
            r_factor   <= n_factor;
            r_prev_fwd <= n_prev_fwd;
            r_prev_rev <= n_prev_rev;
            r_last_lin <= n_last_lin;
            r_last_ang <= n_last_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_accept) begin
            r_in <= i_in_data;
        end
    end

endmodule

>>> rtl/pwdc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwdc_cfg
// APB-style register file holding the gains, thresholds and enables.
// ----------------------------------------------------------------------------
module pwdc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pwdc_pkg::ADDR_W-1:0]   paddr,
    input  logic [pwdc_pkg::DATA_W-1:0]   pwdata,
    output logic [pwdc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output pwdc_pkg::t_cfg                o_cfg
);

    pwdc_pkg::t_cfg r_cfg;
    pwdc_pkg::t_cfg n_cfg;
    logic [2:0]     w_idx;
    logic           w_wr;

    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                pwdc_pkg::REG_LIN_GAIN:           n_cfg.lin_gain           = pwdata[15:0];
                pwdc_pkg::REG_ANG_GAIN:           n_cfg.ang_gain           = pwdata[15:0];
                pwdc_pkg::REG_BOOST_GAIN:         n_cfg.boost_gain         = pwdata[15:0];
                pwdc_pkg::REG_BOOST_EN:           n_cfg.boost_en           = pwdata[0];
                pwdc_pkg::REG_DM_NEEDED:          n_cfg.dm_needed          = pwdata[0];
                pwdc_pkg::REG_THROTTLE_THRESHOLD: n_cfg.throttle_threshold = pwdata[14:0];
                pwdc_pkg::REG_BRAKE_THRESHOLD:    n_cfg.brake_threshold    = pwdata[14:0];
                default:                          n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            pwdc_pkg::REG_LIN_GAIN:           prdata = {16'd0, r_cfg.lin_gain};
            pwdc_pkg::REG_ANG_GAIN:           prdata = {16'd0, r_cfg.ang_gain};
            pwdc_pkg::REG_BOOST_GAIN:         prdata = {16'd0, r_cfg.boost_gain};
            pwdc_pkg::REG_BOOST_EN:           prdata = {31'd0, r_cfg.boost_en};
            pwdc_pkg::REG_DM_NEEDED:          prdata = {31'd0, r_cfg.dm_needed};
            pwdc_pkg::REG_THROTTLE_THRESHOLD: prdata = {17'd0, r_cfg.throttle_threshold};
            pwdc_pkg::REG_BRAKE_THRESHOLD:    prdata = {17'd0, r_cfg.brake_threshold};
            default:                          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lin_gain           <= 16'd4096;
            r_cfg.ang_gain           <= 16'd4096;
            r_cfg.boost_gain         <= 16'd6144;
            r_cfg.boost_en           <= 1'b0;
            r_cfg.dm_needed          <= 1'b0;
            r_cfg.throttle_threshold <= 15'd3277;
            r_cfg.brake_threshold    <= 15'd3277;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> rtl/pwdc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwdc_mul
// Shared unsigned 32x16 multiplier with registered product.
// ----------------------------------------------------------------------------
module pwdc_mul (
    input  logic                          i_clk,
    input  logic [pwdc_pkg::OPA_W-1:0]    i_a,
    input  logic [pwdc_pkg::OPB_W-1:0]    i_b,
    output logic [pwdc_pkg::PROD_W-1:0]   o_prod
);

    logic [pwdc_pkg::PROD_W-1:0] r_prod;
    logic [pwdc_pkg::PROD_W-1:0] n_prod;

    assign n_prod = {{pwdc_pkg::OPB_W{1'b0}}, i_a} * {{pwdc_pkg::OPA_W{1'b0}}, i_b};
    assign o_prod = r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

endmodule
